// ===== src/twra_pkg.sv =====
// shared types and constants for the ternary weight row accumulator
// no dependencies; imported by every module of the block
package twra_pkg;

	// lane and code geometry
	localparam int LANES   = 4;
	localparam int CODE_W  = 2;
	localparam int CODES_W = LANES * CODE_W;

	// accumulator geometry and limits
	localparam int ACC_W = 32;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

	// ternary weight codes
	localparam logic [CODE_W-1:0] CODE_PLUS  = 2'b01;
	localparam logic [CODE_W-1:0] CODE_MINUS = 2'b10;

	// control from the input stage to the accumulator
	typedef struct packed {
		logic fire;
		logic last;
	} twra_step_t;

endpackage

// ===== src/twra_if.sv =====
// valid/ready stream interfaces for activation beats and row results
// depends on twra_pkg for the code and accumulator widths
interface twra_in_if
	import twra_pkg::*;
#(
	parameter int ACT_WIDTH = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [ACT_WIDTH-1:0] act_lane0;
	logic signed [ACT_WIDTH-1:0] act_lane1;
	logic signed [ACT_WIDTH-1:0] act_lane2;
	logic signed [ACT_WIDTH-1:0] act_lane3;
	logic        [CODES_W-1:0]   weight_codes;
	logic                        last_of_row;

	modport source (
		output valid, act_lane0, act_lane1, act_lane2, act_lane3, weight_codes, last_of_row,
		input  ready
	);
	modport sink (
		input  valid, act_lane0, act_lane1, act_lane2, act_lane3, weight_codes, last_of_row,
		output ready
	);
endinterface

interface twra_out_if
	import twra_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] row_sum;
	logic                    saturated;

	modport source (
		output valid, row_sum, saturated,
		input  ready
	);
	modport sink (
		input  valid, row_sum, saturated,
		output ready
	);
endinterface

// ===== src/twra_lane_sum.sv =====
// ternary lane sum: each lane adds, subtracts or drops its activation
// depends on twra_pkg for lane count and weight codes
module twra_lane_sum
	import twra_pkg::*;
#(
	parameter int ACT_WIDTH = 16
) (
	input  logic signed [ACT_WIDTH-1:0]                   act [LANES],
	input  logic        [CODES_W-1:0]                     codes,
	output logic signed [ACT_WIDTH+$clog2(LANES)+1-1:0]   sum
);

	localparam int SUM_W = ACT_WIDTH + $clog2(LANES) + 1;

	// exact sum of the signed lane terms
	always_comb begin
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] term;
		logic [CODE_W-1:0]       code;
		acc = '0;
		for (int k = 0; k < LANES; k++) begin
			code = codes[k*CODE_W +: CODE_W];
			case (code)
				CODE_PLUS:  term = SUM_W'(act[k]);
				CODE_MINUS: term = -SUM_W'(act[k]);
				default:    term = '0;
			endcase
			acc = acc + term;
		end
		sum = acc;
	end

endmodule

// ===== src/twra_accum.sv =====
// saturating row accumulator with sticky clip flag and result register
// depends on twra_pkg and twra_out_if
module twra_accum
	import twra_pkg::*;
#(
	parameter int ACT_WIDTH = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  twra_step_t                                   step,
	input  logic signed [ACT_WIDTH+$clog2(LANES)+1-1:0]  lane_sum,
	twra_out_if.source                                   result
);

	localparam int SUM_W  = ACT_WIDTH + $clog2(LANES) + 1;
	localparam int NEXT_W = ((SUM_W > ACC_W) ? SUM_W : ACC_W) + 1;
	localparam logic signed [NEXT_W-1:0] MAX_X = NEXT_W'(ACC_MAX);
	localparam logic signed [NEXT_W-1:0] MIN_X = NEXT_W'(ACC_MIN);

	logic signed [ACC_W-1:0]  acc_q;
	logic                     clip_q;
	logic signed [NEXT_W-1:0] next_wide;
	logic signed [ACC_W-1:0]  next_sat;
	logic                     clip_now;
	logic                     valid_q;
	logic signed [ACC_W-1:0]  row_sum_q;
	logic                     saturated_q;

	// accumulate and clamp to the 32-bit limits
	always_comb begin
		next_wide = NEXT_W'(acc_q) + NEXT_W'(lane_sum);
		clip_now  = 1'b0;
		next_sat  = next_wide[ACC_W-1:0];
		if (next_wide > MAX_X) begin
			next_sat = ACC_MAX;
			clip_now = 1'b1;
		end else if (next_wide < MIN_X) begin
			next_sat = ACC_MIN;
			clip_now = 1'b1;
		end
	end

	// row state: cleared after the last beat of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				acc_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				acc_q  <= next_sat;
				clip_q <= clip_q | clip_now;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step.fire && step.last) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step.fire && step.last) begin
			row_sum_q   <= next_sat;
			saturated_q <= clip_q | clip_now;
		end
	end

	assign result.valid     = valid_q;
	assign result.row_sum   = row_sum_q;
	assign result.saturated = saturated_q;

`ifndef ASSERT_OFF
	// row state is clear after the closing beat of a row
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && step.last |=> acc_q == '0 && !clip_q)
		else $error("row state not cleared after last beat");

	// clip flag is sticky within a row
	a_clip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && !step.last && clip_q |=> clip_q)
		else $error("clip flag dropped inside a row");
`endif

endmodule

// ===== src/ternary_weight_row_accumulator.sv =====
// a row's last beat passes the input stage register, then its result is held in the output register
// throughput: one beat per cycle; the input stalls only while a last beat waits
// behind an untaken result in the output register
// reset: arst_n clears the stage valid flags, the row accumulator and the clip flag
// depends on twra_pkg, twra_if, twra_lane_sum and twra_accum
module ternary_weight_row_accumulator
	import twra_pkg::*;
#(
	parameter int ACT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	twra_in_if.sink    act_stream,
	twra_out_if.source result
);

	localparam int SUM_W = ACT_WIDTH + $clog2(LANES) + 1;

	logic                        valid_s1;
	logic signed [ACT_WIDTH-1:0] act_s1 [LANES];
	logic        [CODES_W-1:0]   codes_s1;
	logic                        last_s1;
	logic                        accept;
	logic                        advance;
	logic signed [SUM_W-1:0]     lane_sum;
	twra_step_t                  step;

	// handshake: a non-last beat never waits on the result side
	assign advance          = valid_s1 && (!last_s1 || !result.valid || result.ready);
	assign act_stream.ready = !valid_s1 || advance;
	assign accept           = act_stream.valid && act_stream.ready;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1[0] <= act_stream.act_lane0;
			act_s1[1] <= act_stream.act_lane1;
			act_s1[2] <= act_stream.act_lane2;
			act_s1[3] <= act_stream.act_lane3;
			codes_s1  <= act_stream.weight_codes;
			last_s1   <= act_stream.last_of_row;
		end
	end

	twra_lane_sum #(
		.ACT_WIDTH (ACT_WIDTH)
	) u_lane_sum (
		.act   (act_s1),
		.codes (codes_s1),
		.sum   (lane_sum)
	);

	assign step.fire = advance;
	assign step.last = last_s1;

	twra_accum #(
		.ACT_WIDTH (ACT_WIDTH)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.lane_sum (lane_sum),
		.result   (result)
	);

`ifndef ASSERT_OFF
	// input backpressure only from a last beat blocked by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!act_stream.ready |-> valid_s1 && last_s1 && result.valid && !result.ready)
		else $error("input stalled without a blocked row result");

	// every closing beat that leaves the stage produces a result
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> result.valid)
		else $error("closing beat produced no result");
`endif

endmodule

// ===== sim/ternary_weight_row_accumulator_tb.sv =====
// self-checking bench for the ternary weight row accumulator: directed table, then random rows
// depends on twra_pkg, twra_if and ternary_weight_row_accumulator from the rtl
`timescale 1ns / 1ps

module ternary_weight_row_accumulator_tb;
	import twra_pkg::*;

	localparam int ACT_W        = 16;
	localparam int RANDOM_BEATS = 550;
	localparam int CALM_BEATS   = 120;
	localparam int LONG_HOLD    = 80;
	localparam int MAX_REPORTS  = 10;

	// codes that contribute nothing
	localparam logic [CODE_W-1:0] CODE_ZERO = 2'b00;
	localparam logic [CODE_W-1:0] CODE_NULL = 2'b11;

	localparam logic [ACT_W-1:0] ACT_POS_MAX = 16'h7FFF;
	localparam logic [ACT_W-1:0] ACT_NEG_MAX = 16'h8000;

	typedef struct packed {
		logic [ACT_W-1:0]   act_lane0;
		logic [ACT_W-1:0]   act_lane1;
		logic [ACT_W-1:0]   act_lane2;
		logic [ACT_W-1:0]   act_lane3;
		logic [CODES_W-1:0] weight_codes;
		logic               last_of_row;
	} beat_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] row_sum;
		logic                    saturated;
	} row_result_t;

	// one line of the directed table; a beat may repeat to build a long row
	typedef struct {
		beat_t       beat;
		int          reps;
		bit          typed;
		row_result_t result;
	} directed_row_t;

	logic clk;
	logic arst_n;

	twra_in_if #(.ACT_WIDTH(ACT_W)) act_if ();
	twra_out_if                     res_if ();

	ternary_weight_row_accumulator #(.ACT_WIDTH(ACT_W)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.act_stream (act_if.sink),
		.result     (res_if.source)
	);

	// predictor state
	logic signed [ACC_W-1:0] row_acc;
	logic                    row_clipped;

	row_result_t   pending_rows [$];
	directed_row_t directed_tab [$];
	int            errors;
	bit            calm;
	bit            stall_now;
	bit            stall_done;

	always #5 clk = ~clk;

	// fold one beat into the running row sum; returns 1 when the beat closes a row
	function automatic bit fold_beat_into_row(input beat_t b, output row_result_t res);
		logic [ACT_W-1:0]   lanes [LANES];
		logic [CODE_W-1:0]  code;
		longint             lane_total;
		longint             next_acc;
		lanes[0] = b.act_lane0;
		lanes[1] = b.act_lane1;
		lanes[2] = b.act_lane2;
		lanes[3] = b.act_lane3;
		lane_total = 0;
		for (int k = 0; k < LANES; k++) begin
			code = b.weight_codes[k*CODE_W +: CODE_W];
			if (code == CODE_PLUS)
				lane_total += longint'($signed(lanes[k]));
			else if (code == CODE_MINUS)
				lane_total -= longint'($signed(lanes[k]));
		end
		next_acc = longint'(row_acc) + lane_total;
		if (next_acc > longint'(ACC_MAX)) begin
			next_acc    = longint'(ACC_MAX);
			row_clipped = 1'b1;
		end else if (next_acc < longint'(ACC_MIN)) begin
			next_acc    = longint'(ACC_MIN);
			row_clipped = 1'b1;
		end
		row_acc = next_acc[ACC_W-1:0];
		res.row_sum   = row_acc;
		res.saturated = row_clipped;
		if (!b.last_of_row)
			return 1'b0;
		row_acc     = '0;
		row_clipped = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [ACT_W-1:0] pick_activation();
		case ($urandom_range(0, 7))
			0: return ACT_POS_MAX;
			1: return ACT_NEG_MAX;
			2: return '0;
			3: return '1;
			default: return ACT_W'($urandom);
		endcase
	endfunction

	task automatic tab(input int a0, input int a1, input int a2, input int a3,
			input logic [CODES_W-1:0] codes, input bit last, input int reps,
			input bit typed, input longint sum, input bit sat);
		directed_row_t r;
		r.beat         = '{ACT_W'(a0), ACT_W'(a1), ACT_W'(a2), ACT_W'(a3), codes, last};
		r.reps         = reps;
		r.typed        = typed;
		r.result       = '{ACC_W'(sum), sat};
		directed_tab.push_back(r);
	endtask

	// offer one beat from a falling edge, wait for the handshake, log the prediction
	task automatic send_beat(input beat_t b, input bit typed, input row_result_t typed_res);
		row_result_t predicted;
		if (!calm && $urandom_range(0, 5) == 0) begin
			act_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		act_if.act_lane0    <= b.act_lane0;
		act_if.act_lane1    <= b.act_lane1;
		act_if.act_lane2    <= b.act_lane2;
		act_if.act_lane3    <= b.act_lane3;
		act_if.weight_codes <= b.weight_codes;
		act_if.last_of_row  <= b.last_of_row;
		act_if.valid        <= 1'b1;
		@(posedge clk);
		while (!act_if.ready)
			@(posedge clk);
		if (fold_beat_into_row(b, predicted))
			pending_rows.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// result side: random stall bursts plus one long hold-off
	initial begin : result_sink
		int idle_left;
		int hold_left;
		idle_left    = 0;
		hold_left    = 0;
		stall_done   = 1'b0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_now && !stall_done) begin
				stall_done = 1'b1;
				hold_left  = LONG_HOLD - 1;
				res_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				res_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				idle_left = $urandom_range(1, 11) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_rows.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: unexpected row result sum=%0d sat=%0b",
						$realtime, res_if.row_sum, res_if.saturated);
				errors++;
			end else begin
				want = pending_rows.pop_front();
				if (res_if.row_sum !== want.row_sum || res_if.saturated !== want.saturated) begin
					if (errors < MAX_REPORTS)
						$display("%0t: row mismatch exp sum=%0d sat=%0b got sum=%0d sat=%0b",
							$realtime, want.row_sum, want.saturated,
							res_if.row_sum, res_if.saturated);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		beat_t       b;
		row_result_t none;
		int          sent;
		int          row_len;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		errors              = 0;
		calm                = 1'b0;
		stall_now           = 1'b0;
		row_acc             = '0;
		row_clipped         = 1'b0;
		none                = '0;
		act_if.valid        = 1'b0;
		act_if.act_lane0    = '0;
		act_if.act_lane1    = '0;
		act_if.act_lane2    = '0;
		act_if.act_lane3    = '0;
		act_if.weight_codes = '0;
		act_if.last_of_row  = 1'b0;

		// extremes and codes
		tab(0, 0, 0, 0, {4{CODE_ZERO}}, 1, 1, 1, 0, 0);
		tab(32767, 32767, -32768, -32768, {4{CODE_NULL}}, 1, 1, 1, 0, 0);
		tab(32767, 32767, 32767, 32767, {4{CODE_PLUS}}, 1, 1, 1, 131068, 0);
		tab(-32768, -32768, -32768, -32768, {4{CODE_MINUS}}, 1, 1, 1, 131072, 0);
		tab(-32768, -32768, -32768, -32768, {4{CODE_PLUS}}, 1, 1, 1, -131072, 0);
		tab(32767, 32767, 32767, 32767, {4{CODE_MINUS}}, 1, 1, 1, -131068, 0);
		tab(100, 200, 300, 400, {CODE_ZERO, CODE_PLUS, CODE_MINUS, CODE_NULL}, 1, 1, 0, 0, 0);
		tab(1234, -5, 77, -32768, {CODE_MINUS, CODE_PLUS, CODE_NULL, CODE_PLUS}, 0, 3, 0, 0, 0);
		tab(-1, 1, -2, 2, {CODE_PLUS, CODE_MINUS, CODE_PLUS, CODE_MINUS}, 1, 1, 0, 0, 0);
		tab(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h66, 1, 1, 0, 0, 0);
		tab(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'h99, 1, 1, 0, 0, 0);
		tab(0, 0, 0, 0, {4{CODE_PLUS}}, 1, 1, 1, 0, 0);
		tab(1, 0, 0, 0, {CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_PLUS}, 1, 1, 1, 1, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_tab[i]) begin
			for (int r = 0; r < directed_tab[i].reps; r++) begin
				b = directed_tab[i].beat;
				if (r != directed_tab[i].reps - 1)
					b.last_of_row = 1'b0;
				send_beat(b, directed_tab[i].typed && b.last_of_row, directed_tab[i].result);
			end
		end

		// random rows; single-beat rows once the long hold is requested, until it starts
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			if (sent >= 150 && !stall_now)
				stall_now = 1'b1;
			if (sent >= RANDOM_BEATS - CALM_BEATS)
				calm = 1'b1;
			if (stall_now && !stall_done)
				row_len = 1;
			else if ($urandom_range(0, 9) == 0)
				row_len = 1;
			else
				row_len = $urandom_range(2, 8);
			for (int k = 0; k < row_len; k++) begin
				b.act_lane0    = pick_activation();
				b.act_lane1    = pick_activation();
				b.act_lane2    = pick_activation();
				b.act_lane3    = pick_activation();
				b.weight_codes = CODES_W'($urandom_range(0, 255));
				b.last_of_row  = (k == row_len - 1);
				send_beat(b, 1'b0, none);
				sent++;
			end
		end
		act_if.valid <= 1'b0;

		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
